>>> rtl/core/seven_segment_strip_clock_renderer_assert.svh
// Assertion macros shared by the renderer's checker.
`ifndef SEVEN_SEGMENT_STRIP_CLOCK_RENDERER_ASSERT_SVH
`define SEVEN_SEGMENT_STRIP_CLOCK_RENDERER_ASSERT_SVH

// Same-cycle implication.
`define SSSR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SSSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sssr_pkg.sv
// Shared types, constants and helper functions of the strip clock renderer.
`default_nettype none

package sssr_pkg;

    localparam int LEDS_PER_SEGMENT = 2;
    localparam int DIGIT_LEDS       = 7 * LEDS_PER_SEGMENT;
    localparam int SEP_LEDS         = 2 + LEDS_PER_SEGMENT;
    localparam int STRIP_LEDS       = 4 * DIGIT_LEDS + SEP_LEDS;
    localparam int SEP_START        = 2 * DIGIT_LEDS;
    localparam int IDX_W            = 6;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    localparam logic CMD_TIME  = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    localparam logic [2:0] REG_COLOR_RED      = 3'd0;
    localparam logic [2:0] REG_COLOR_GREEN    = 3'd1;
    localparam logic [2:0] REG_COLOR_BLUE     = 3'd2;
    localparam logic [2:0] REG_FADE_TIME_MS   = 3'd3;
    localparam logic [2:0] REG_SEPARATOR_KIND = 3'd4;

    localparam logic [2:0] SEP_APOSTROPHE = 3'd0;
    localparam logic [2:0] SEP_DASH       = 3'd1;
    localparam logic [2:0] SEP_DOT        = 3'd2;
    localparam logic [2:0] SEP_COLON      = 3'd3;

    localparam logic [7:0] LEVEL_FULL = 8'd255;

    typedef struct packed {
        logic [7:0]  color_red;
        logic [7:0]  color_green;
        logic [7:0]  color_blue;
        logic [15:0] fade_time_ms;
        logic [2:0]  separator_kind;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        color_red:      8'd0,
        color_green:    8'd128,
        color_blue:     8'd0,
        fade_time_ms:   16'd300,
        separator_kind: SEP_COLON
    };

    typedef struct packed {
        logic        is_frame;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [31:0] now_ms;
    } op_t;

    typedef struct packed {
        logic [IDX_W-1:0] led_index;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic             last;
    } pixel_t;

    typedef logic [STRIP_LEDS-1:0] pattern_t;

    function automatic logic [6:0] seg_code(logic [3:0] d);
        logic [6:0] code;
        unique case (d)
            4'd0:    code = 7'h7e;
            4'd1:    code = 7'h18;
            4'd2:    code = 7'h37;
            4'd3:    code = 7'h3d;
            4'd4:    code = 7'h59;
            4'd5:    code = 7'h6d;
            4'd6:    code = 7'h6f;
            4'd7:    code = 7'h38;
            4'd8:    code = 7'h7f;
            4'd9:    code = 7'h7d;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

    function automatic logic [3:0] tens_of(logic [5:0] v);
        logic [3:0] t;
        priority if (v >= 6'd60) t = 4'd6;
        else if (v >= 6'd50)     t = 4'd5;
        else if (v >= 6'd40)     t = 4'd4;
        else if (v >= 6'd30)     t = 4'd3;
        else if (v >= 6'd20)     t = 4'd2;
        else if (v >= 6'd10)     t = 4'd1;
        else                     t = 4'd0;
        return t;
    endfunction

    function automatic logic [3:0] ones_of(logic [5:0] v);
        logic [5:0] t10;
        logic [5:0] r;
        t10 = 6'(tens_of(v)) * 6'd10;
        r   = v - t10;
        return r[3:0];
    endfunction

    function automatic pattern_t render(logic [4:0] hour, logic [5:0] minute,
                                        logic [2:0] sep);
        pattern_t   pat;
        logic [3:0] d [4];
        logic [6:0] bits;
        int         base;
        pat  = '0;
        d[0] = tens_of({1'b0, hour});
        d[1] = ones_of({1'b0, hour});
        d[2] = tens_of(minute);
        d[3] = ones_of(minute);
        for (int dg = 0; dg < 4; dg++) begin
            base = dg * DIGIT_LEDS + ((dg >= 2) ? SEP_LEDS : 0);
            bits = seg_code(d[dg]);
            for (int s = 0; s < 7; s++) begin
                for (int k = 0; k < LEDS_PER_SEGMENT; k++) begin
                    pat[base + s * LEDS_PER_SEGMENT + k] = bits[6 - s];
                end
            end
        end
        unique case (sep)
            SEP_APOSTROPHE: pat[SEP_START] = 1'b1;
            SEP_DASH:
            begin
                pat[SEP_START + 1] = 1'b1;
                pat[SEP_START + 2] = 1'b1;
            end
            SEP_DOT:        pat[SEP_START + SEP_LEDS - 1] = 1'b1;
            SEP_COLON:
            begin
                pat[SEP_START] = 1'b1;
                pat[SEP_START + SEP_LEDS - 1] = 1'b1;
            end
            default: ;
        endcase
        return pat;
    endfunction

    // floor(x / 255), exact for every product of two 8-bit values
    function automatic logic [7:0] div255(logic [15:0] x);
        logic [15:0] x1;
        logic [15:0] y;
        x1 = x + 16'd1;
        y  = x1 + (x1 >> 8);
        return y[15:8];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/seven_segment_strip_clock_renderer.sv
// Top level of the seven-segment strip clock renderer.
//
//   channel   handshake               payload
//   input     push / full             cmd, hour, minute, now_ms
//   result    empty / pop             led_index, red, green, blue, last
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A time request is applied in the dispatch state alone. A frame request runs one
// dispatch, eight divider steps for the fade progress while a fade is partway, one LED
// per cycle over 60 LEDs while a result credit is free, and one commit step.
// The LED walk is paced by credits on the four-entry result queue.
// Reset is immediate; no clearing pass. cfg_ready is always high.
`default_nettype none

module seven_segment_strip_clock_renderer (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire logic           cmd,
    input  wire logic [4:0]     hour,
    input  wire logic [5:0]     minute,
    input  wire logic [31:0]    now_ms,
    output logic                empty,
    input  wire logic           pop,
    output logic [5:0]          led_index,
    output logic [7:0]          red,
    output logic [7:0]          green,
    output logic [7:0]          blue,
    output logic                last,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [15:0]    cfg_data
);

    sssr_pkg::cfg_t                     cfg_reg, cfg_next;
    logic                               q_full;
    logic                               q_push;
    sssr_pkg::op_t                      q_din;
    logic                               q_pop;
    sssr_pkg::op_t                      q_dout;
    logic                               q_empty;
    logic [sssr_pkg::OUTQ_CW-1:0]       oq_count;
    logic                               oq_push;
    sssr_pkg::pixel_t                   oq_din;
    sssr_pkg::pixel_t                   oq_dout;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                sssr_pkg::REG_COLOR_RED:      cfg_next.color_red      = cfg_data[7:0];
                sssr_pkg::REG_COLOR_GREEN:    cfg_next.color_green    = cfg_data[7:0];
                sssr_pkg::REG_COLOR_BLUE:     cfg_next.color_blue     = cfg_data[7:0];
                sssr_pkg::REG_FADE_TIME_MS:   cfg_next.fade_time_ms   = cfg_data;
                sssr_pkg::REG_SEPARATOR_KIND: cfg_next.separator_kind = cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= sssr_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sssr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .cmd    (cmd),
        .hour   (hour),
        .minute (minute),
        .now_ms (now_ms),
        .full   (full),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_din)
    );

    sssr_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    sssr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_data   (q_dout),
        .q_pop    (q_pop),
        .oq_count (oq_count),
        .oq_push  (oq_push),
        .oq_data  (oq_din)
    );

    sssr_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .din   (oq_din),
        .count (oq_count),
        .pop   (pop),
        .dout  (oq_dout),
        .empty (empty)
    );

    assign led_index = oq_dout.led_index;
    assign red       = oq_dout.red;
    assign green     = oq_dout.green;
    assign blue      = oq_dout.blue;
    assign last      = oq_dout.last;

endmodule

`default_nettype wire

>>> rtl/core/sssr_front.sv
// Input side: accepts requests and drops time requests that change nothing.
`default_nettype none

module sssr_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire logic           cmd,
    input  wire logic [4:0]     hour,
    input  wire logic [5:0]     minute,
    input  wire logic [31:0]    now_ms,
    output logic                full,
    input  wire logic           q_full,
    output logic                q_push,
    output sssr_pkg::op_t       q_data
);

    logic [7:0] last_hour_reg, last_hour_next;
    logic [7:0] last_minute_reg, last_minute_next;
    logic       accept;
    logic       is_frame;
    logic       changed;

    assign full     = q_full;
    assign accept   = push && !q_full;
    assign is_frame = (cmd == sssr_pkg::CMD_FRAME);
    assign changed  = ({3'b0, hour} != last_hour_reg) || ({2'b0, minute} != last_minute_reg);

    always_comb
    begin
        last_hour_next   = last_hour_reg;
        last_minute_next = last_minute_reg;
        q_push           = 1'b0;
        if (accept) begin
            if (is_frame) begin
                q_push = 1'b1;
            end else if (changed) begin
                q_push           = 1'b1;
                last_hour_next   = {3'b0, hour};
                last_minute_next = {2'b0, minute};
            end
        end
    end

    assign q_data = '{is_frame: is_frame, hour: hour, minute: minute, now_ms: now_ms};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            last_hour_reg   <= 8'hff;
            last_minute_reg <= 8'hff;
        end else begin
            last_hour_reg   <= last_hour_next;
            last_minute_reg <= last_minute_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sssr_cmdq.sv
// Short request queue between the input side and the renderer engine.
`default_nettype none

module sssr_cmdq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire sssr_pkg::op_t  din,
    output logic                full,
    input  wire logic           pop,
    output sssr_pkg::op_t       dout,
    output logic                empty
);

    sssr_pkg::op_t                   mem_reg [sssr_pkg::CMDQ_DEPTH];
    logic [sssr_pkg::CMDQ_AW-1:0]    wr_reg, wr_next;
    logic [sssr_pkg::CMDQ_AW-1:0]    rd_reg, rd_next;
    logic [sssr_pkg::CMDQ_CW-1:0]    cnt_reg, cnt_next;
    logic                            do_push;
    logic                            do_pop;

    assign full    = (cnt_reg == sssr_pkg::CMDQ_CW'(sssr_pkg::CMDQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + sssr_pkg::CMDQ_CW'(do_push) - sssr_pkg::CMDQ_CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sssr_outq.sv
// Result queue holding finished pixels until the consumer pops them.
`default_nettype none

module sssr_outq (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire sssr_pkg::pixel_t               din,
    output logic [sssr_pkg::OUTQ_CW-1:0]        count,
    input  wire logic                           pop,
    output sssr_pkg::pixel_t                    dout,
    output logic                                empty
);

    sssr_pkg::pixel_t                mem_reg [sssr_pkg::OUTQ_DEPTH];
    logic [sssr_pkg::OUTQ_AW-1:0]    wr_reg, wr_next;
    logic [sssr_pkg::OUTQ_AW-1:0]    rd_reg, rd_next;
    logic [sssr_pkg::OUTQ_CW-1:0]    cnt_reg, cnt_next;
    logic                            do_push;
    logic                            do_pop;

    assign count   = cnt_reg;
    assign empty   = (cnt_reg == '0);
    // the engine only pushes when it holds a credit
    assign do_push = push && (cnt_reg != sssr_pkg::OUTQ_CW'(sssr_pkg::OUTQ_DEPTH));
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + sssr_pkg::OUTQ_CW'(do_push) - sssr_pkg::OUTQ_CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sssr_back.sv
// Renderer engine: applies time requests, runs the fade divider, emits pixels.
`default_nettype none

module sssr_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire sssr_pkg::cfg_t             cfg,
    input  wire logic                       q_empty,
    input  wire sssr_pkg::op_t              q_data,
    output logic                            q_pop,
    input  wire logic [sssr_pkg::OUTQ_CW-1:0] oq_count,
    output logic                            oq_push,
    output sssr_pkg::pixel_t                oq_data
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIVIDE = 4'b0010,
        ST_EMIT   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    localparam int N = sssr_pkg::STRIP_LEDS;

    state_t                         state_reg, state_next;
    sssr_pkg::pattern_t             shown_reg, shown_next;
    sssr_pkg::pattern_t             target_reg, target_next;
    sssr_pkg::pattern_t             from_reg, from_next;
    logic                           fading_reg, fading_next;
    logic [31:0]                    start_reg, start_next;
    logic [7:0]                     prog_reg, prog_next;
    logic [23:0]                    rem_reg, rem_next;
    logic [22:0]                    dsh_reg, dsh_next;
    logic [2:0]                     step_reg, step_next;
    logic [sssr_pkg::IDX_W-1:0]     pix_reg, pix_next;
    logic                           p1_valid_reg;
    logic [sssr_pkg::IDX_W-1:0]     p1_idx_reg;
    logic                           p1_last_reg;
    logic [15:0]                    p1_r_reg, p1_g_reg, p1_b_reg;

    logic [31:0]                    elapsed;
    logic                           fade_on;
    logic                           late;
    logic                           ge;
    logic                           credit;
    logic                           issue;
    logic [7:0]                     lvl;
    sssr_pkg::pattern_t             rendered;

    assign elapsed  = q_data.now_ms - start_reg;
    assign fade_on  = fading_reg && (cfg.fade_time_ms != 16'd0);
    assign late     = (elapsed >= {16'd0, cfg.fade_time_ms});
    assign ge       = (rem_reg >= {1'b0, dsh_reg});
    assign credit   = (4'(oq_count) + 4'(p1_valid_reg)) < 4'(sssr_pkg::OUTQ_DEPTH);
    assign issue    = (state_reg == ST_EMIT) && credit;
    assign rendered = sssr_pkg::render(q_data.hour, q_data.minute, cfg.separator_kind);

    // on/off blend reduces to a choice between full, zero, progress and its complement
    always_comb
    begin
        if (fading_reg) begin
            priority if (from_reg[0] && target_reg[0]) lvl = sssr_pkg::LEVEL_FULL;
            else if (from_reg[0])                      lvl = ~prog_reg;
            else if (target_reg[0])                    lvl = prog_reg;
            else                                       lvl = 8'd0;
        end else begin
            lvl = shown_reg[0] ? sssr_pkg::LEVEL_FULL : 8'd0;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        shown_next  = shown_reg;
        target_next = target_reg;
        from_next   = from_reg;
        fading_next = fading_reg;
        start_next  = start_reg;
        prog_next   = prog_reg;
        rem_next    = rem_reg;
        dsh_next    = dsh_reg;
        step_next   = step_reg;
        pix_next    = pix_reg;
        q_pop       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    if (!q_data.is_frame) begin
                        // commit a running fade, then fade from what is shown
                        from_next   = fading_reg ? target_reg : shown_reg;
                        shown_next  = fading_reg ? target_reg : shown_reg;
                        target_next = rendered;
                        start_next  = q_data.now_ms;
                        fading_next = (cfg.fade_time_ms != 16'd0);
                        if (cfg.fade_time_ms == 16'd0) begin
                            shown_next = rendered;
                        end
                    end else begin
                        pix_next = '0;
                        if (fade_on && !late) begin
                            rem_next   = {elapsed[15:0], 8'd0} - {8'd0, elapsed[15:0]};
                            dsh_next   = {cfg.fade_time_ms, 7'd0};
                            step_next  = '1;
                            state_next = ST_DIVIDE;
                        end else begin
                            prog_next  = sssr_pkg::LEVEL_FULL;
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (ge) begin
                    rem_next = rem_reg - {1'b0, dsh_reg};
                end
                prog_next = {prog_reg[6:0], ge};
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg - 3'd1;
                if (step_reg == 3'd0) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (issue) begin
                    // rotate so the next LED sits at bit zero; a full pass restores order
                    shown_next  = {shown_reg[0], shown_reg[N-1:1]};
                    target_next = {target_reg[0], target_reg[N-1:1]};
                    from_next   = {from_reg[0], from_reg[N-1:1]};
                    if (pix_reg == sssr_pkg::IDX_W'(N - 1)) begin
                        state_next = ST_FINISH;
                    end else begin
                        pix_next = pix_reg + 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (fading_reg && (prog_reg == sssr_pkg::LEVEL_FULL)) begin
                    shown_next  = target_reg;
                    fading_next = 1'b0;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prog_reg <= prog_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        step_reg <= step_next;
        if (issue) begin
            p1_idx_reg  <= pix_reg;
            p1_last_reg <= (pix_reg == sssr_pkg::IDX_W'(N - 1));
            p1_r_reg    <= 16'(cfg.color_red) * 16'(lvl);
            p1_g_reg    <= 16'(cfg.color_green) * 16'(lvl);
            p1_b_reg    <= 16'(cfg.color_blue) * 16'(lvl);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            shown_reg    <= '0;
            target_reg   <= '0;
            from_reg     <= '0;
            fading_reg   <= 1'b0;
            start_reg    <= '0;
            pix_reg      <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            shown_reg    <= shown_next;
            target_reg   <= target_next;
            from_reg     <= from_next;
            fading_reg   <= fading_next;
            start_reg    <= start_next;
            pix_reg      <= pix_next;
            p1_valid_reg <= issue;
        end
    end

    assign oq_push = p1_valid_reg;
    assign oq_data = '{
        led_index: p1_idx_reg,
        red:       sssr_pkg::div255(p1_r_reg),
        green:     sssr_pkg::div255(p1_g_reg),
        blue:      sssr_pkg::div255(p1_b_reg),
        last:      p1_last_reg
    };

endmodule

`default_nettype wire

>>> rtl/core/sssr_checker.sv
// Port-level checks on the renderer's result channel, bound to the top level.
`default_nettype none
`include "seven_segment_strip_clock_renderer_assert.svh"

module sssr_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       empty,
    input  wire logic       pop,
    input  wire logic [5:0] led_index,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,
    input  wire logic       last
);

    localparam logic [5:0] LAST_IDX = 6'(sssr_pkg::STRIP_LEDS - 1);

    `SSSR_ASSERT_SAME(a_last_at_end, clk, rst_n, !empty && last, led_index == LAST_IDX, "last flag away from final LED")
    `SSSR_ASSERT_SAME(a_end_is_last, clk, rst_n, !empty && (led_index == LAST_IDX), last, "final LED without last flag")
    `SSSR_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop, !empty, "waiting result vanished")
    `SSSR_ASSERT_NEXT(a_payload_stable, clk, rst_n, !empty && !pop, $stable(led_index) && $stable(red) && $stable(green) && $stable(blue) && $stable(last), "waiting result changed")

endmodule

bind seven_segment_strip_clock_renderer sssr_checker u_sssr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .led_index (led_index),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .last      (last)
);

`default_nettype wire

>>> dv/tb_seven_segment_strip_clock_renderer.sv
// Self-checking testbench for the seven-segment strip clock renderer.
module tb_seven_segment_strip_clock_renderer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] SEP_BLANK   = 3'd4;
    localparam logic [2:0] SEP_UNKNOWN = 3'd7;
    localparam int SETTLE_CYCLES = 120;
    localparam int STALL_LIMIT   = 4000;
    localparam int CYCLE_CAP     = 2000000;
    localparam int LONG_HOLD     = 500;
    localparam int PHASE_ITEMS   = 48;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        cmd = 1'b0;
    logic [4:0]  hour = '0;
    logic [5:0]  minute = '0;
    logic [31:0] now_ms = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [5:0]  led_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    seven_segment_strip_clock_renderer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .hour      (hour),
        .minute    (minute),
        .now_ms    (now_ms),
        .empty     (empty),
        .pop       (pop),
        .led_index (led_index),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Renderer state as the testbench sees it
    logic [6:0]  glyph_bits [10] = '{7'h7e, 7'h18, 7'h37, 7'h3d, 7'h59,
                                     7'h6d, 7'h6f, 7'h38, 7'h7f, 7'h7d};
    sssr_pkg::cfg_t     cfg_model;
    sssr_pkg::pattern_t shown_leds;
    sssr_pkg::pattern_t target_leds;
    sssr_pkg::pattern_t from_leds;
    logic        fade_active;
    logic [31:0] fade_origin;
    logic [7:0]  prev_hour;
    logic [7:0]  prev_minute;

    sssr_pkg::op_t    clock_requests[$];
    sssr_pkg::pixel_t expected_pixels[$];
    int     pixel_errors = 0;

    // Sender and receiver pacing
    int burst_left = 8;
    int gap_left = 0;
    int pop_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    int pattern_ctr = 0;
    bit hold_req = 1'b0;
    bit hold_seen = 1'b0;

    // Stimulus generation state
    int          gen_hour = 0;
    int          gen_minute = 0;
    logic [31:0] gen_clock = '0;

    function automatic sssr_pkg::pattern_t draw_face(input logic [4:0] h,
                                                     input logic [5:0] m,
                                                     input logic [2:0] sep);
        sssr_pkg::pattern_t face;
        int         digit [4];
        int         base;
        logic [6:0] bits;
        face = '0;
        digit[0] = h / 10;
        digit[1] = h % 10;
        digit[2] = m / 10;
        digit[3] = m % 10;
        for (int dg = 0; dg < 4; dg++)
        begin
            base = dg * sssr_pkg::DIGIT_LEDS + ((dg >= 2) ? sssr_pkg::SEP_LEDS : 0);
            bits = glyph_bits[digit[dg]];
            for (int s = 0; s < 7; s++)
            begin
                for (int k = 0; k < sssr_pkg::LEDS_PER_SEGMENT; k++)
                begin
                    face[base + s * sssr_pkg::LEDS_PER_SEGMENT + k] = bits[6 - s];
                end
            end
        end
        case (sep)
            sssr_pkg::SEP_APOSTROPHE: face[sssr_pkg::SEP_START] = 1'b1;
            sssr_pkg::SEP_DASH:
            begin
                face[sssr_pkg::SEP_START + 1] = 1'b1;
                face[sssr_pkg::SEP_START + 2] = 1'b1;
            end
            sssr_pkg::SEP_DOT: face[sssr_pkg::SEP_START + sssr_pkg::SEP_LEDS - 1] = 1'b1;
            sssr_pkg::SEP_COLON:
            begin
                face[sssr_pkg::SEP_START] = 1'b1;
                face[sssr_pkg::SEP_START + sssr_pkg::SEP_LEDS - 1] = 1'b1;
            end
            default: ;
        endcase
        return face;
    endfunction

    task automatic reset_renderer();
        cfg_model   = sssr_pkg::CFG_RESET;
        shown_leds  = '0;
        target_leds = '0;
        from_leds   = '0;
        fade_active = 1'b0;
        fade_origin = '0;
        prev_hour   = 8'd255;
        prev_minute = 8'd255;
    endtask

    // Apply one accepted request and queue the pixels it must produce
    task automatic advance_renderer(input sssr_pkg::op_t r);
        logic [31:0] delta;
        int unsigned progress;
        int unsigned from_lvl;
        int unsigned to_lvl;
        int unsigned lvl;
        sssr_pkg::pixel_t px;
        if (r.is_frame == sssr_pkg::CMD_TIME)
        begin
            if ({3'b000, r.hour} != prev_hour || {2'b00, r.minute} != prev_minute)
            begin
                prev_hour   = {3'b000, r.hour};
                prev_minute = {2'b00, r.minute};
                if (fade_active)
                begin
                    shown_leds  = target_leds;
                    fade_active = 1'b0;
                end
                from_leds   = shown_leds;
                target_leds = draw_face(r.hour, r.minute, cfg_model.separator_kind);
                fade_origin = r.now_ms;
                fade_active = (cfg_model.fade_time_ms != 16'd0);
                if (!fade_active)
                    shown_leds = target_leds;
            end
        end
        else
        begin
            progress = 255;
            if (fade_active && cfg_model.fade_time_ms != 16'd0)
            begin
                delta = r.now_ms - fade_origin;
                if (delta >= {16'd0, cfg_model.fade_time_ms})
                    progress = 255;
                else
                    progress = (delta * 255) / cfg_model.fade_time_ms;
            end
            for (int i = 0; i < sssr_pkg::STRIP_LEDS; i++)
            begin
                if (fade_active)
                begin
                    from_lvl = from_leds[i] ? 255 : 0;
                    to_lvl   = target_leds[i] ? 255 : 0;
                end
                else
                begin
                    from_lvl = shown_leds[i] ? 255 : 0;
                    to_lvl   = from_lvl;
                end
                lvl = (from_lvl * (255 - progress) + to_lvl * progress + 127) / 255;
                px.led_index = i[5:0];
                px.red       = 8'((cfg_model.color_red * lvl) / 255);
                px.green     = 8'((cfg_model.color_green * lvl) / 255);
                px.blue      = 8'((cfg_model.color_blue * lvl) / 255);
                px.last      = (i == sssr_pkg::STRIP_LEDS - 1);
                expected_pixels.push_back(px);
            end
            if (fade_active && progress >= 255)
            begin
                shown_leds  = target_leds;
                fade_active = 1'b0;
            end
        end
    endtask

    function automatic void check_field(input string field, input longint unsigned want_v,
                                        input longint unsigned got_v);
        if (want_v != got_v)
        begin
            pixel_errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field,
                     want_v, got_v);
        end
    endfunction

    // Driver: present queued requests in bursts, hold each until taken
    always @(posedge clk)
    begin : send
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                advance_renderer(clock_requests.pop_front());
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 6);
                end
            end
            if (!(push && full))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (clock_requests.size() > 0)
                begin
                    push   <= 1'b1;
                    cmd    <= clock_requests[0].is_frame;
                    hour   <= clock_requests[0].hour;
                    minute <= clock_requests[0].minute;
                    now_ms <= clock_requests[0].now_ms;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Monitor: take pixels on a stall pattern and compare with the oldest expectation
    always @(posedge clk)
    begin : receive
        sssr_pkg::pixel_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_pixels.size() == 0)
                begin
                    pixel_errors++;
                    $display("%0t: unexpected pixel, expected none, got led %0d",
                             $time, led_index);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("led_index", want.led_index, led_index);
                    check_field("red", want.red, red);
                    check_field("green", want.green, green);
                    check_field("blue", want.blue, blue);
                    check_field("last", want.last, last);
                end
            end
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                pop_mode  = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            else
                mode_left--;
            pattern_ctr++;
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                case (pop_mode)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom_range(0, 1));
                    2: pop <= ($urandom_range(0, 3) == 0);
                    default: pop <= (pattern_ctr % 3 != 0);
                endcase
            end
        end
    end

    // Watchdog on cycles without any accepted transfer and on the total run length
    int idle_cycles = 0;
    int total_cycles = 0;
    always @(posedge clk)
    begin
        total_cycles <= total_cycles + 1;
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT || total_cycles >= CYCLE_CAP)
        begin
            $display("%0t: no progress, %0d pixels still expected", $time,
                     expected_pixels.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            sssr_pkg::REG_COLOR_RED:      cfg_model.color_red      = data[7:0];
            sssr_pkg::REG_COLOR_GREEN:    cfg_model.color_green    = data[7:0];
            sssr_pkg::REG_COLOR_BLUE:     cfg_model.color_blue     = data[7:0];
            sssr_pkg::REG_FADE_TIME_MS:   cfg_model.fade_time_ms   = data;
            sssr_pkg::REG_SEPARATOR_KIND: cfg_model.separator_kind = data[2:0];
            default: ;
        endcase
    endtask

    // Wait for every request and pixel, then let the engine finish trailing time requests
    task automatic settle();
        while (clock_requests.size() != 0 || push || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_time(input int h, input int m, input logic [31:0] t);
        sssr_pkg::op_t r;
        r.is_frame = sssr_pkg::CMD_TIME;
        r.hour     = h[4:0];
        r.minute   = m[5:0];
        r.now_ms   = t;
        clock_requests.push_back(r);
    endtask

    task automatic queue_frame(input logic [31:0] t);
        sssr_pkg::op_t r;
        r.is_frame = sssr_pkg::CMD_FRAME;
        r.hour     = 5'($urandom());
        r.minute   = 6'($urandom());
        r.now_ms   = t;
        clock_requests.push_back(r);
    endtask

    function automatic logic [31:0] frame_step(input logic [15:0] fade);
        if (fade == 16'd0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, 70000);
        return $urandom_range(0, fade / 2 + 1);
    endfunction

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 4))
            0: return {8'($urandom()), 8'h00};
            1: return {8'($urandom()), 8'hff};
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic queue_random_phase(input int n, input logic [15:0] fade);
        int made;
        int roll;
        made = 0;
        gen_clock = $urandom();
        while (made < n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                // new time followed by frames that walk through the fade
                if ($urandom_range(0, 3) == 0)
                begin
                    gen_hour   = $urandom_range(0, 31);
                    gen_minute = $urandom_range(0, 63);
                end
                else
                begin
                    gen_minute = (gen_minute + 1) % 64;
                    if (gen_minute >= 60)
                    begin
                        gen_minute = 0;
                        gen_hour = (gen_hour + 1) % 24;
                    end
                end
                queue_time(gen_hour, gen_minute, gen_clock);
                made++;
                repeat ($urandom_range(1, 4))
                begin
                    gen_clock = gen_clock + frame_step(fade);
                    queue_frame(gen_clock);
                    made++;
                end
            end
            else if (roll < 85)
            begin
                // same time again must not restart the fade
                queue_time(gen_hour, gen_minute, $urandom());
                gen_clock = gen_clock + frame_step(fade);
                queue_frame(gen_clock);
                made++;
            end
            else
            begin
                gen_clock = $urandom();
                queue_frame(gen_clock);
                made++;
            end
        end
    endtask

    initial
    begin : stimulus
        int          sep_hours [5];
        int          sep_minutes [5];
        logic [2:0]  sep_kinds [5];
        logic [15:0] fade;
        sep_hours   = '{0, 23, 31, 10, 19};
        sep_minutes = '{0, 59, 63, 47, 36};
        sep_kinds   = '{sssr_pkg::SEP_APOSTROPHE, sssr_pkg::SEP_DASH, sssr_pkg::SEP_DOT,
                        SEP_BLANK, SEP_UNKNOWN};
        reset_renderer();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: dark strip, then a full fade at the default length
        queue_frame(32'd500);
        queue_time(12, 34, 32'd1000);
        queue_frame(32'd1000);
        queue_frame(32'd1150);
        queue_frame(32'd1300);
        queue_frame(32'd1400);
        settle();

        // Instant switch, full color, apostrophe, dash, dot, blank and unknown separators
        write_reg(sssr_pkg::REG_COLOR_RED, 16'hffff);
        write_reg(sssr_pkg::REG_COLOR_GREEN, 16'hffff);
        write_reg(sssr_pkg::REG_COLOR_BLUE, 16'hffff);
        write_reg(sssr_pkg::REG_FADE_TIME_MS, 16'd0);
        for (int k = 0; k < 5; k++)
        begin
            write_reg(sssr_pkg::REG_SEPARATOR_KIND, {13'd0, sep_kinds[k]});
            queue_time(sep_hours[k], sep_minutes[k], 32'(k * 100));
            queue_frame(32'(k * 100 + 5));
            settle();
        end
        queue_time(sep_hours[4], sep_minutes[4], 32'hdead_beef);
        queue_frame(32'd7);
        settle();

        // Longest fade across the 32-bit wrap of the timestamp
        write_reg(sssr_pkg::REG_FADE_TIME_MS, 16'hffff);
        write_reg(sssr_pkg::REG_SEPARATOR_KIND, {13'd0, sssr_pkg::SEP_COLON});
        queue_time(7, 7, 32'hffff_ff00);
        queue_frame(32'h0000_0100);
        queue_frame(32'hffff_fe00);
        settle();

        for (int p = 0; p < 8; p++)
        begin
            write_reg(sssr_pkg::REG_COLOR_RED, (p == 0) ? 16'h0000 : pick_level());
            write_reg(sssr_pkg::REG_COLOR_GREEN, (p == 0) ? 16'h00ff : pick_level());
            write_reg(sssr_pkg::REG_COLOR_BLUE, (p == 0) ? 16'h0080 : pick_level());
            case (p)
                0: fade = 16'd1;
                1: fade = 16'hffff;
                2: fade = 16'd0;
                3: fade = 16'($urandom_range(1, 40));
                7: fade = 16'($urandom());
                default: fade = 16'($urandom_range(100, 3000));
            endcase
            write_reg(sssr_pkg::REG_FADE_TIME_MS, fade);
            write_reg(sssr_pkg::REG_SEPARATOR_KIND, {13'd0, 3'(p)});
            // hold off the receiver so the block backs up into its input
            if (p == 4)
                hold_req = ~hold_req;
            queue_random_phase(PHASE_ITEMS, fade);
            settle();
        end

        if (pixel_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/sssr_pkg.sv
rtl/core/sssr_front.sv
rtl/core/sssr_cmdq.sv
rtl/core/sssr_outq.sv
rtl/core/sssr_back.sv
rtl/core/seven_segment_strip_clock_renderer.sv
rtl/core/sssr_checker.sv
dv/tb_seven_segment_strip_clock_renderer.sv
